// ===== rtl/ihex_pkg.sv =====
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, constants and the microcode table of the Intel HEX encoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

   localparam int BUF_DEPTH = 16;
   localparam int BUF_AW    = 4;
   localparam int FILL_W    = 5;
   localparam int STEP_W    = 5;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_EOF  = 1'b1;

   localparam logic [6:0] CH_COLON = 7'h3A;
   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_ONE   = 7'h31;
   localparam logic [6:0] CH_F     = 7'h46;
   localparam logic [6:0] CH_CR    = 7'h0D;
   localparam logic [6:0] CH_LF    = 7'h0A;

   localparam logic [STEP_W-1:0] STEP_LINE    = 5'd0;
   localparam logic [STEP_W-1:0] STEP_DATA_HI = 5'd9;
   localparam logic [STEP_W-1:0] STEP_EOF     = 5'd15;
   localparam logic [STEP_W-1:0] STEP_LAST    = 5'd27;

   typedef enum logic [1:0] {
      CS_LIT = 2'd0,
      CS_HI  = 2'd1,
      CS_LO  = 2'd2
   } char_sel_type;

   typedef enum logic [2:0] {
      BS_COUNT = 3'd0,
      BS_AHI   = 3'd1,
      BS_ALO   = 3'd2,
      BS_ZERO  = 3'd3,
      BS_DATA  = 3'd4,
      BS_CSUM  = 3'd5
   } byte_sel_type;

   typedef enum logic [1:0] {
      J_NEXT = 2'd0,
      J_DATA = 2'd1,
      J_LINE = 2'd2,
      J_END  = 2'd3
   } jump_type;

   typedef struct packed {
      char_sel_type csel;
      logic [6:0]   lit;
      byte_sel_type bsel;
      logic         acc;
      jump_type     jmp;
   } uword_type;

   typedef struct packed {
      logic         start;
      logic         emit;
      char_sel_type csel;
      logic [6:0]   lit;
      byte_sel_type bsel;
      logic         acc;
      logic         k_inc;
      logic         last;
      logic         line_done;
   } dp_ctl_type;

   typedef struct packed {
      logic out_free;
      logic fill_zero;
      logic full_next;
      logic k_more;
   } dp_stat_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] n7;
      n7 = {3'b000, nib};
      hex_char = (nib < 4'd10) ? 7'(n7 + CH_ZERO) : 7'(n7 + 7'h37);
   endfunction

   // microcode ROM: one output character per step
   function automatic uword_type ucode(input logic [STEP_W-1:0] step);
      uword_type w;
      w = '{CS_LIT, CH_LF, BS_ZERO, 1'b0, J_END};
      unique case (step)
         5'd0:  w = '{CS_LIT, CH_COLON, BS_ZERO,  1'b0, J_NEXT};
         5'd1:  w = '{CS_HI,  CH_ZERO,  BS_COUNT, 1'b0, J_NEXT};
         5'd2:  w = '{CS_LO,  CH_ZERO,  BS_COUNT, 1'b1, J_NEXT};
         5'd3:  w = '{CS_HI,  CH_ZERO,  BS_AHI,   1'b0, J_NEXT};
         5'd4:  w = '{CS_LO,  CH_ZERO,  BS_AHI,   1'b1, J_NEXT};
         5'd5:  w = '{CS_HI,  CH_ZERO,  BS_ALO,   1'b0, J_NEXT};
         5'd6:  w = '{CS_LO,  CH_ZERO,  BS_ALO,   1'b1, J_NEXT};
         5'd7:  w = '{CS_LIT, CH_ZERO,  BS_ZERO,  1'b0, J_NEXT};
         5'd8:  w = '{CS_LIT, CH_ZERO,  BS_ZERO,  1'b0, J_NEXT};
         5'd9:  w = '{CS_HI,  CH_ZERO,  BS_DATA,  1'b0, J_NEXT};
         5'd10: w = '{CS_LO,  CH_ZERO,  BS_DATA,  1'b1, J_DATA};
         5'd11: w = '{CS_HI,  CH_ZERO,  BS_CSUM,  1'b0, J_NEXT};
         5'd12: w = '{CS_LO,  CH_ZERO,  BS_CSUM,  1'b0, J_NEXT};
         5'd13: w = '{CS_LIT, CH_CR,    BS_ZERO,  1'b0, J_NEXT};
         5'd14: w = '{CS_LIT, CH_LF,    BS_ZERO,  1'b0, J_LINE};
         5'd15: w = '{CS_LIT, CH_COLON, BS_ZERO,  1'b0, J_NEXT};
         5'd16: w = '{CS_LIT, CH_ZERO,  BS_ZERO,  1'b0, J_NEXT};
         5'd17: w = '{CS_LIT, CH_ZERO,  BS_ZERO,  1'b0, J_NEXT};
         5'd18: w = '{CS_LIT, CH_ZERO,  BS_ZERO,  1'b0, J_NEXT};
         5'd19: w = '{CS_LIT, CH_ZERO,  BS_ZERO,  1'b0, J_NEXT};
         5'd20: w = '{CS_LIT, CH_ZERO,  BS_ZERO,  1'b0, J_NEXT};
         5'd21: w = '{CS_LIT, CH_ZERO,  BS_ZERO,  1'b0, J_NEXT};
         5'd22: w = '{CS_LIT, CH_ZERO,  BS_ZERO,  1'b0, J_NEXT};
         5'd23: w = '{CS_LIT, CH_ONE,   BS_ZERO,  1'b0, J_NEXT};
         5'd24: w = '{CS_LIT, CH_F,     BS_ZERO,  1'b0, J_NEXT};
         5'd25: w = '{CS_LIT, CH_F,     BS_ZERO,  1'b0, J_NEXT};
         5'd26: w = '{CS_LIT, CH_CR,    BS_ZERO,  1'b0, J_NEXT};
         5'd27: w = '{CS_LIT, CH_LF,    BS_ZERO,  1'b0, J_END};
         default: w = '{CS_LIT, CH_LF,  BS_ZERO,  1'b0, J_END};
      endcase
      ucode = w;
   endfunction

endpackage

// ===== rtl/ihex_datapath.sv =====
// ----------------------------------------------------------------------------
// ihex_datapath
// Line buffer, fill count, start address, checksum and output character
// register, driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module ihex_datapath #(
   parameter int RECORD_BYTES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_accept,
   input  logic                     req_cmd,
   input  logic [7:0]               req_data_byte,
   input  logic [15:0]              req_byte_address,
   input  ihex_pkg::dp_ctl_type     ctl,
   output ihex_pkg::dp_stat_type    stat,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [6:0]               rsp_out_char,
   output logic                     rsp_last_char
);

   logic [7:0]                    buf_mem [ihex_pkg::BUF_DEPTH];
   logic [7:0]                    rd_ff;
   logic [ihex_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic [ihex_pkg::FILL_W-1:0]   k_ff, k_in;
   logic [15:0]                   addr_ff;
   logic [7:0]                    sum_ff, sum_in;
   logic                          valid_ff, valid_in;
   logic [6:0]                    char_ff;
   logic                          last_ff;
   logic [7:0]                    sel_byte;
   logic [6:0]                    sel_char;
   logic                          wr_data;

   assign wr_data = req_accept && (req_cmd == ihex_pkg::CMD_DATA);

   always_comb begin
      fill_in = fill_ff;
      if (wr_data) begin
         fill_in = ihex_pkg::FILL_W'(fill_ff + 1'b1);
      end else if (ctl.line_done) begin
         fill_in = '0;
      end
   end

   always_comb begin
      k_in = k_ff;
      if (ctl.start) begin
         k_in = '0;
      end else if (ctl.k_inc) begin
         k_in = ihex_pkg::FILL_W'(k_ff + 1'b1);
      end
   end

   always_comb begin
      case (ctl.bsel)
         ihex_pkg::BS_COUNT: sel_byte = {3'b000, fill_ff};
         ihex_pkg::BS_AHI:   sel_byte = addr_ff[15:8];
         ihex_pkg::BS_ALO:   sel_byte = addr_ff[7:0];
         ihex_pkg::BS_DATA:  sel_byte = rd_ff;
         ihex_pkg::BS_CSUM:  sel_byte = 8'(8'd0 - sum_ff);
         default:            sel_byte = 8'd0;
      endcase
   end

   always_comb begin
      case (ctl.csel)
         ihex_pkg::CS_HI: sel_char = ihex_pkg::hex_char(sel_byte[7:4]);
         ihex_pkg::CS_LO: sel_char = ihex_pkg::hex_char(sel_byte[3:0]);
         default:         sel_char = ctl.lit;
      endcase
   end

   always_comb begin
      sum_in = sum_ff;
      if (ctl.start) begin
         sum_in = '0;
      end else if (ctl.emit && ctl.acc) begin
         sum_in = 8'(sum_ff + sel_byte);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         addr_ff  <= '0;
         k_ff     <= '0;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         k_ff     <= k_in;
         sum_ff   <= sum_in;
         valid_ff <= valid_in;
         if (wr_data && (fill_ff == '0)) begin
            addr_ff <= req_byte_address;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_data) begin
         buf_mem[fill_ff[ihex_pkg::BUF_AW-1:0]] <= req_data_byte;
      end
      rd_ff <= buf_mem[k_in[ihex_pkg::BUF_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         char_ff <= sel_char;
         last_ff <= ctl.last;
      end
   end

   assign stat.out_free  = !valid_ff || rsp_ready;
   assign stat.fill_zero = (fill_ff == '0);
   assign stat.full_next = (ihex_pkg::FILL_W'(fill_ff + 1'b1)
                            >= ihex_pkg::FILL_W'(RECORD_BYTES));
   assign stat.k_more    = (ihex_pkg::FILL_W'(k_ff + 1'b1) < fill_ff);

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= ihex_pkg::FILL_W'(RECORD_BYTES))
      else $error("line fill beyond record size");
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit && ctl.bsel == ihex_pkg::BS_DATA) |-> (k_ff < fill_ff))
      else $error("data index past fill");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> (!valid_ff || rsp_ready))
      else $error("output register overwritten");

endmodule

// ===== rtl/ihex_sequencer.sv =====
// ----------------------------------------------------------------------------
// ihex_sequencer
// Step counter over the microcode table, with data loop and end-of-line
// jumps; launches a program for each item that produces text.
// ----------------------------------------------------------------------------
module ihex_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_accept,
   input  logic                     req_cmd,
   input  logic                     req_last_of_chunk,
   input  ihex_pkg::dp_stat_type    stat,
   output ihex_pkg::dp_ctl_type     ctl,
   output logic                     req_ready
);

   logic                          busy_ff, busy_in;
   logic [ihex_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          eofp_ff, eofp_in;
   ihex_pkg::uword_type           uw;

   always_comb begin
      uw        = ihex_pkg::ucode(step_ff);
      busy_in   = busy_ff;
      step_in   = step_ff;
      eofp_in   = eofp_ff;
      ctl.start = !busy_ff;
      ctl.emit  = 1'b0;
      ctl.csel  = uw.csel;
      ctl.lit   = uw.lit;
      ctl.bsel  = uw.bsel;
      ctl.acc   = uw.acc;
      ctl.k_inc = 1'b0;
      ctl.last  = 1'b0;
      ctl.line_done = 1'b0;
      if (!busy_ff) begin
         if (req_accept) begin
            if (req_cmd == ihex_pkg::CMD_DATA) begin
               if (stat.full_next || req_last_of_chunk) begin
                  busy_in = 1'b1;
                  step_in = ihex_pkg::STEP_LINE;
                  eofp_in = 1'b0;
               end
            end else begin
               busy_in = 1'b1;
               eofp_in = 1'b1;
               step_in = stat.fill_zero ? ihex_pkg::STEP_EOF : ihex_pkg::STEP_LINE;
            end
         end
      end else if (stat.out_free) begin
         ctl.emit = 1'b1;
         unique case (uw.jmp)
            ihex_pkg::J_NEXT: begin
               step_in = ihex_pkg::STEP_W'(step_ff + 1'b1);
            end
            ihex_pkg::J_DATA: begin
               ctl.k_inc = 1'b1;
               step_in = stat.k_more ? ihex_pkg::STEP_DATA_HI
                                     : ihex_pkg::STEP_W'(step_ff + 1'b1);
            end
            ihex_pkg::J_LINE: begin
               ctl.line_done = 1'b1;
               if (eofp_ff) begin
                  step_in = ihex_pkg::STEP_EOF;
               end else begin
                  ctl.last = 1'b1;
                  busy_in  = 1'b0;
               end
            end
            ihex_pkg::J_END: begin
               ctl.last = 1'b1;
               busy_in  = 1'b0;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         eofp_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         eofp_ff <= eofp_in;
      end
   end

   assign req_ready = !busy_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= ihex_pkg::STEP_LAST))
      else $error("step counter out of program");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit && ctl.last) |=> !busy_ff)
      else $error("sequencer busy after final character");
   a_eof_entry: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_cmd == ihex_pkg::CMD_EOF) |=> (busy_ff && eofp_ff))
      else $error("end command did not start end-of-file program");

endmodule

// ===== rtl/intel_hex_record_encoder_top.sv =====
// ----------------------------------------------------------------------------
// intel_hex_record_encoder_top
// Intel HEX data record encoder, 16-bit addresses, microcoded sequencer.
// ----------------------------------------------------------------------------
// Input channel (req_*): one item per code byte (cmd = 0) with its load
// address and an end-of-chunk mark, or an end command (cmd = 1). Bytes are
// buffered until RECORD_BYTES are held or a chunk ends; the line is then
// sent on the result channel (rsp_*) as ASCII text, one character per item:
// ':' count address "00" data checksum CR LF. An end command flushes a
// partial line and then sends ":00000001FF" CR LF. rsp_last_char marks the
// final character caused by one input item.
// Timing: a buffered byte with no output leaves req_ready high. A record
// with N data bytes is 2N + 13 characters, the end-of-file record 13; the
// item holds the input until its last character is loaded. One character
// leaves per cycle while rsp_ready is high, from the single output register
// fed by the microcode step counter. req_ready is low while a program runs.
// Receiver stall: the sequencer holds its step while a character waits in
// the output register and rsp_ready is low; no character is lost. Reset
// empties the line and idles the sequencer.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder_top #(
   parameter int RECORD_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_byte_address,
   input  logic        req_last_of_chunk,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_out_char,
   output logic        rsp_last_char
);

   ihex_pkg::dp_ctl_type  ctl;
   ihex_pkg::dp_stat_type stat;
   logic                  req_accept;

   assign req_accept = req_valid && req_ready;

   ihex_sequencer u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_accept        (req_accept),
      .req_cmd           (req_cmd),
      .req_last_of_chunk (req_last_of_chunk),
      .stat              (stat),
      .ctl               (ctl),
      .req_ready         (req_ready)
   );

   ihex_datapath #(
      .RECORD_BYTES (RECORD_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_accept       (req_accept),
      .req_cmd          (req_cmd),
      .req_data_byte    (req_data_byte),
      .req_byte_address (req_byte_address),
      .ctl              (ctl),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_char    (rsp_last_char)
   );

endmodule
